/* rtl/etc1bd_pkg.sv */
// ----------------------------------------------------------------------------
// etc1bd_pkg
// Types, constant tables and helpers shared by the ETC1 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package etc1bd_pkg;

   localparam logic [3:0] LAST_POS = 4'd15;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Base colors of both sub-blocks, already expanded to eight bits.
   typedef struct packed {
      rgb_type base0;
      rgb_type base1;
      logic    bad;
   } base_type;

   // Everything about one block that the pixel stage needs.
   typedef struct packed {
      logic [15:0] sel_lo;
      logic [15:0] sel_hi;
      logic [7:0]  control;
      base_type    bases;
      logic [63:0] alphas;
   } block_type;

   typedef struct packed {
      logic [3:0] position;
      rgb_type    color;
      logic [7:0] alpha;
      logic       bad;
      logic       last;
   } pixel_type;

   // Intensity modifier for a table and a 2-bit selector.
   function automatic logic signed [8:0] mod_value(input logic [2:0] tbl,
                                                   input logic [1:0] sel);
      logic [7:0] mag;
      begin
         mag = 8'd0;
         unique case (tbl)
            3'd0: mag = sel[0] ? 8'd8   : 8'd2;
            3'd1: mag = sel[0] ? 8'd17  : 8'd5;
            3'd2: mag = sel[0] ? 8'd29  : 8'd9;
            3'd3: mag = sel[0] ? 8'd42  : 8'd13;
            3'd4: mag = sel[0] ? 8'd60  : 8'd18;
            3'd5: mag = sel[0] ? 8'd80  : 8'd24;
            3'd6: mag = sel[0] ? 8'd106 : 8'd33;
            3'd7: mag = sel[0] ? 8'd183 : 8'd47;
            default: mag = 8'd0;
         endcase
         // The high selector bit picks the negative half of the table.
         mod_value = sel[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   endfunction

   // Block pixel index (column * 4 + row) decoded at each output position.
   function automatic logic [3:0] pixel_index(input logic [3:0] pos);
      logic [3:0] idx;
      begin
         idx = 4'd0;
         unique case (pos)
            4'd0:  idx = 4'd0;
            4'd1:  idx = 4'd4;
            4'd2:  idx = 4'd1;
            4'd3:  idx = 4'd5;
            4'd4:  idx = 4'd8;
            4'd5:  idx = 4'd12;
            4'd6:  idx = 4'd9;
            4'd7:  idx = 4'd13;
            4'd8:  idx = 4'd2;
            4'd9:  idx = 4'd6;
            4'd10: idx = 4'd3;
            4'd11: idx = 4'd7;
            4'd12: idx = 4'd10;
            4'd13: idx = 4'd14;
            4'd14: idx = 4'd11;
            4'd15: idx = 4'd15;
            default: idx = 4'd0;
         endcase
         pixel_index = idx;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/etc1_block_decoder_core.sv */
// ----------------------------------------------------------------------------
// etc1_block_decoder_core
// Decodes 4x4 ETC1 blocks with optional 4-bit alpha into RGBA pixels.
//
//   channel   direction  handshake          payload
//   request   in         start / busy       req_* block fields
//   response  out        rsp_strobe         rsp_* pixel fields
//   csr       in         csr_valid/ready    csr_wdata (alpha_present)
//
// A block yields 16 pixels, one per cycle, or a single error pixel when a
// differential base is out of range. The pixel counter over the held block
// sets the rate; the block is registered, and each pixel is registered again
// before it goes out. busy drops during a block's final pixel so the next
// block is taken without a gap. Responses cannot be stalled. Reset is
// synchronous and clears the control state and alpha_present.
// ----------------------------------------------------------------------------
`default_nettype none

module etc1_block_decoder_core
   import etc1bd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_selector_low_plane,
   input  logic [15:0] req_selector_high_plane,
   input  logic [7:0]  req_control_byte,
   input  logic [7:0]  req_red_byte,
   input  logic [7:0]  req_green_byte,
   input  logic [7:0]  req_blue_byte,
   input  logic [63:0] req_alpha_nibbles,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_pixel_position,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_bad_block,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);

   base_type  req_bases;
   block_type blk_ff, blk_in;
   logic      active_ff, active_in;
   logic [3:0] cnt_ff, cnt_in;
   logic      alpha_present_ff, alpha_present_in;
   pixel_type pixel;
   pixel_type rsp_ff, rsp_in;
   logic      rsp_strobe_ff, rsp_strobe_in;
   logic      last_now;
   logic      accept;

   etc1bd_base_decode u_base (
      .differential (req_control_byte[1]),
      .red_byte     (req_red_byte),
      .green_byte   (req_green_byte),
      .blue_byte    (req_blue_byte),
      .bases        (req_bases)
   );

   etc1bd_pixel_unit u_pixel (
      .blk           (blk_ff),
      .position      (cnt_ff),
      .alpha_present (alpha_present_ff),
      .pixel         (pixel)
   );

   // The held block finishes this cycle on its last pixel or its error pixel.
   assign last_now  = active_ff && (blk_ff.bases.bad || cnt_ff == LAST_POS);
   assign busy      = active_ff && !last_now;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      blk_in           = blk_ff;
      active_in        = active_ff;
      cnt_in           = cnt_ff;
      alpha_present_in = alpha_present_ff;
      rsp_in           = rsp_ff;
      rsp_strobe_in    = active_ff;
      if (active_ff) begin
         rsp_in    = pixel;
         cnt_in    = cnt_ff + 4'd1;
         active_in = !last_now;
      end
      if (accept) begin
         blk_in.sel_lo  = req_selector_low_plane;
         blk_in.sel_hi  = req_selector_high_plane;
         blk_in.control = req_control_byte;
         blk_in.bases   = req_bases;
         blk_in.alphas  = req_alpha_nibbles;
         active_in      = 1'b1;
         cnt_in         = 4'd0;
      end
      if (csr_valid && csr_ready) begin
         alpha_present_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         cnt_ff           <= 4'd0;
         alpha_present_ff <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         active_ff        <= active_in;
         cnt_ff           <= cnt_in;
         alpha_present_ff <= alpha_present_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_pixel_position = rsp_ff.position;
   assign rsp_red_out        = rsp_ff.color.red;
   assign rsp_green_out      = rsp_ff.color.green;
   assign rsp_blue_out       = rsp_ff.color.blue;
   assign rsp_alpha_out      = rsp_ff.alpha;
   assign rsp_bad_block      = rsp_ff.bad;
   assign rsp_last_pixel     = rsp_ff.last;

   // An error response always closes its block.
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bad_block) |-> rsp_last_pixel)
      else $error("error response without last_pixel");

   // Pixels of one block come out in consecutive cycles.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_pixel) |=> rsp_strobe)
      else $error("gap inside a block's responses");

   // A taken block shows its first response after the block and response registers.
   a_first_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("no response after a taken block");

   // On a good block, last_pixel marks exactly the final position.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_bad_block) |-> (rsp_last_pixel == (rsp_pixel_position == LAST_POS)))
      else $error("last_pixel does not match the final position");

endmodule

`default_nettype wire

/* rtl/etc1bd_base_decode.sv */
// ----------------------------------------------------------------------------
// etc1bd_base_decode
// Expands the two base colors of a block and flags a differential base that
// leaves the 5-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module etc1bd_base_decode
   import etc1bd_pkg::*;
(
   input  logic       differential,
   input  logic [7:0] red_byte,
   input  logic [7:0] green_byte,
   input  logic [7:0] blue_byte,
   output base_type   bases
);

   logic [7:0] b0_chan [3];
   logic [7:0] b1_chan [3];
   logic [2:0] chan_bad;
   logic [7:0] chan_byte [3];

   assign chan_byte[0] = red_byte;
   assign chan_byte[1] = green_byte;
   assign chan_byte[2] = blue_byte;

   always_comb begin
      logic [6:0] sum;
      logic [4:0] a5;
      logic [4:0] b5;
      for (int c = 0; c < 3; c++) begin
         a5  = chan_byte[c][7:3];
         sum = {2'b00, a5} + {{4{chan_byte[c][2]}}, chan_byte[c][2:0]};
         b5  = sum[4:0];
         if (differential) begin
            b0_chan[c]  = {a5, a5[4:2]};
            b1_chan[c]  = {b5, b5[4:2]};
            // Sign bit set means below zero, bit 5 set means above 31.
            chan_bad[c] = sum[6] | sum[5];
         end else begin
            b0_chan[c]  = {chan_byte[c][7:4], chan_byte[c][7:4]};
            b1_chan[c]  = {chan_byte[c][3:0], chan_byte[c][3:0]};
            chan_bad[c] = 1'b0;
         end
      end
   end

   assign bases.base0 = '{red: b0_chan[0], green: b0_chan[1], blue: b0_chan[2]};
   assign bases.base1 = '{red: b1_chan[0], green: b1_chan[1], blue: b1_chan[2]};
   assign bases.bad   = |chan_bad;

endmodule

`default_nettype wire

/* rtl/etc1bd_pixel_unit.sv */
// ----------------------------------------------------------------------------
// etc1bd_pixel_unit
// Decodes one output pixel of a registered block: sub-block choice, modifier
// lookup, clamped add per channel, alpha expansion; an error pixel if bad.
// ----------------------------------------------------------------------------
`default_nettype none

module etc1bd_pixel_unit
   import etc1bd_pkg::*;
(
   input  block_type  blk,
   input  logic [3:0] position,
   input  logic       alpha_present,
   output pixel_type  pixel
);

   logic [3:0]        idx;
   logic              second;
   logic [2:0]        tbl;
   logic [1:0]        sel;
   logic signed [8:0] modifier;
   rgb_type           base;
   logic [3:0]        nibble;

   function automatic logic [7:0] clamp_add(input logic [7:0] b,
                                             input logic signed [8:0] m);
      logic signed [9:0] s;
      begin
         s = $signed({2'b00, b}) + {m[8], m};
         if (s[9])
            clamp_add = 8'd0;
         else if (s[8])
            clamp_add = 8'd255;
         else
            clamp_add = s[7:0];
      end
   endfunction

   assign idx      = pixel_index(position);
   // With flip set the second sub-block is rows 2..3, otherwise columns 2..3.
   assign second   = blk.control[0] ? idx[1] : idx[3];
   assign tbl      = second ? blk.control[4:2] : blk.control[7:5];
   assign sel      = {blk.sel_hi[idx], blk.sel_lo[idx]};
   assign modifier = mod_value(tbl, sel);
   assign base     = second ? blk.bases.base1 : blk.bases.base0;
   assign nibble   = blk.alphas[{position, 2'b00} +: 4];

   always_comb begin
      if (blk.bases.bad) begin
         pixel      = '0;
         pixel.bad  = 1'b1;
         pixel.last = 1'b1;
      end else begin
         pixel.position    = position;
         pixel.color.red   = clamp_add(base.red, modifier);
         pixel.color.green = clamp_add(base.green, modifier);
         pixel.color.blue  = clamp_add(base.blue, modifier);
         pixel.alpha       = alpha_present ? {nibble, nibble} : 8'hFF;
         pixel.bad         = 1'b0;
         pixel.last        = (position == LAST_POS);
      end
   end

endmodule

`default_nettype wire
